// ===== src/lrukv_pkg.sv =====
// Shared types and constants of the LRU key/value cache.
// No dependencies; every other file refers to it by scoped names.
package lrukv_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // capacity register
  localparam int                CAP_W     = 5;
  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(ENTRIES);

  // configuration bus
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;   // word index paddr[2]

  // request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                         op;
    logic signed [KEY_BITS-1:0]   key;
    logic signed [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] read_value;
  } rsp_t;

endpackage

// ===== src/lrukv_apb.sv =====
// APB register slave holding the capacity register.
// Depends on lrukv_pkg.
module lrukv_apb (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrukv_pkg::PADDR_W-1:0]     paddr,
  input  logic [lrukv_pkg::PDATA_W-1:0]     pwdata,
  output logic [lrukv_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  output logic [lrukv_pkg::CAP_W-1:0]       capacity
);

  logic sel_capacity;

  assign pready       = 1'b1;
  assign sel_capacity = (paddr[2] == lrukv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lrukv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && sel_capacity) begin
      capacity <= pwdata[lrukv_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_capacity) begin
      prdata = {{(lrukv_pkg::PDATA_W - lrukv_pkg::CAP_W){1'b0}}, capacity};
    end
  end

endmodule

// ===== src/lrukv_core.sv =====
// Entry storage, parallel key match, recency ages and replacement choice.
// Depends on lrukv_pkg. State changes at the edge where fire is high.
module lrukv_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  lrukv_pkg::req_t               req,
  input  logic [lrukv_pkg::CAP_W-1:0]   capacity,
  output lrukv_pkg::rsp_t               rsp
);

  localparam int N  = lrukv_pkg::ENTRIES;
  localparam int IW = lrukv_pkg::IDX_W;
  localparam int CW = lrukv_pkg::CNT_W;

  logic signed [lrukv_pkg::KEY_BITS-1:0]   keys   [N];
  logic signed [lrukv_pkg::VALUE_BITS-1:0] values [N];
  logic [N-1:0]  valid;
  logic [IW-1:0] ages [N];
  logic [CW-1:0] count;

  logic [N-1:0]  match;
  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic [IW-1:0] lru_idx;
  logic [IW-1:0] tgt_idx;
  logic [IW-1:0] tgt_age;
  logic [IW-1:0] wr_idx;
  logic [CW-1:0] limit;
  logic [CW-1:0] count_m1;
  logic          full;
  logic          is_put;

  assign is_put = (req.op == lrukv_pkg::OP_PUT);

  // effective capacity: zero counts as one, large values saturate
  always_comb begin
    if (capacity == '0) begin
      limit = CW'(1);
    end else if (int'(capacity) > N) begin
      limit = CW'(N);
    end else begin
      limit = CW'(capacity);
    end
  end

  assign full     = (count >= limit);
  assign count_m1 = count - CW'(1);

  // valid ages form a permutation of 0 .. count-1, so the oldest entry
  // is the one whose age equals count-1
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    lru_idx  = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = valid[i] && (keys[i] == req.key);
      if (match[i]) begin
        hit_idx = IW'(i);
      end
      if (!valid[i]) begin
        free_idx = IW'(i);
      end
      if (valid[i] && (ages[i] == count_m1[IW-1:0])) begin
        lru_idx = IW'(i);
      end
    end
    hit_any = |match;
  end

  assign tgt_idx = hit_any ? hit_idx : lru_idx;
  assign tgt_age = ages[tgt_idx];

  always_comb begin
    if (hit_any) begin
      wr_idx = hit_idx;
    end else if (full) begin
      wr_idx = lru_idx;
    end else begin
      wr_idx = free_idx;
    end
  end

  assign rsp.hit        = hit_any;
  assign rsp.read_value = hit_any ? values[hit_idx] : '0;

  // control state: valid bits, ages, fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < N; i++) begin
        ages[i] <= '0;
      end
    end else if (fire) begin
      if (hit_any || (is_put && full)) begin
        // move target to the front, age the younger entries
        for (int i = 0; i < N; i++) begin
          if (valid[i] && (IW'(i) != tgt_idx) && (ages[i] < tgt_age)) begin
            ages[i] <= ages[i] + IW'(1);
          end
        end
        ages[tgt_idx] <= '0;
      end else if (is_put) begin
        for (int i = 0; i < N; i++) begin
          if (valid[i]) begin
            ages[i] <= ages[i] + IW'(1);
          end
        end
        valid[free_idx] <= 1'b1;
        ages[free_idx]  <= '0;
        count           <= count + CW'(1);
      end
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (fire && is_put) begin
      values[wr_idx] <= req.value;
      if (!hit_any) begin
        keys[wr_idx] <= req.key;
      end
    end
  end

endmodule

// ===== src/lru_key_value_cache_core.sv =====
// LRU key/value cache: a fully associative store of up to 16 entries whose
// capacity is set over an APB register; a get returns hit and the stored value
// (0 on a miss), a put updates or inserts, evicting the least recently used
// entry once the store holds capacity entries. Each request is registered, then
// resolved by a parallel compare of all keys and an age-counter update, so one
// request is taken per clock unless a get waits for a stalled result register;
// a get's result is captured in the result register when it leaves the request
// stage; a put returns nothing. The result register lets puts flow while a get
// result waits. Depends on lrukv_pkg, lrukv_apb and lrukv_core.
module lru_key_value_cache_core (
  input  logic                                    clk,
  input  logic                                    rst,
  // configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [lrukv_pkg::PADDR_W-1:0]           paddr,
  input  logic [lrukv_pkg::PDATA_W-1:0]           pwdata,
  output logic [lrukv_pkg::PDATA_W-1:0]           prdata,
  output logic                                    pready,
  // requests
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    op,
  input  logic signed [lrukv_pkg::KEY_BITS-1:0]   key,
  input  logic signed [lrukv_pkg::VALUE_BITS-1:0] value,
  // results
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic                                    hit,
  output logic signed [lrukv_pkg::VALUE_BITS-1:0] read_value
);

  logic [lrukv_pkg::CAP_W-1:0] capacity;
  logic                        s_valid;
  lrukv_pkg::req_t             s_req;
  lrukv_pkg::rsp_t             rsp;
  logic                        advance;
  logic                        accept;
  logic                        s_valid_next;

  lrukv_apb u_apb (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  lrukv_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .req      (s_req),
    .capacity (capacity),
    .rsp      (rsp)
  );

  // a put always leaves the stage; a get needs room in the result register
  assign advance  = s_valid && ((s_req.op == lrukv_pkg::OP_PUT) || !out_valid || !out_stall);
  assign in_stall = s_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      s_valid_next = 1'b1;
    end else if (advance) begin
      s_valid_next = 1'b0;
    end else begin
      s_valid_next = s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= s_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_req.op    <= op;
      s_req.key   <= key;
      s_req.value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (s_req.op == lrukv_pkg::OP_GET)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s_req.op == lrukv_pkg::OP_GET)) begin
      hit        <= rsp.hit;
      read_value <= rsp.read_value;
    end
  end

endmodule

// ===== src/lrukv_checker.sv =====
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lrukv_pkg and lru_key_value_cache_core.
module lrukv_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    op,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic                                    hit,
  input logic signed [lrukv_pkg::VALUE_BITS-1:0] read_value
);

  // a held result stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
    else $error("result dropped or changed while stalled");

  // a miss reads as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == '0)
    else $error("miss with nonzero read_value");

  // a put never blocks the request that follows it
  a_put_flows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == lrukv_pkg::OP_PUT) |=> !in_stall)
    else $error("stall behind a put");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lru_key_value_cache_core lrukv_checker u_lrukv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .op         (op),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hit        (hit),
  .read_value (read_value)
);
